[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
// expects clk and rst in the scope of the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every edge out of reset
`define HATG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define HATG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/hatg_pkg.sv]
// constants, types and the gamma threshold table of the hdr resolve block
// no dependencies
package hatg_pkg;

  localparam int SUM_WIDTH        = 40;
  localparam int SUM_FRAC_BITS    = 16;
  localparam int GAMMA_TABLE_BITS = 12;

  localparam int FRAMES_W   = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int BYTE_W     = 8;

  // register indexes
  localparam logic [CFG_ADDR_W-3:0] REG_FRAMES = '0;
  localparam int FRAMES_RESET = 1;

  // exposure 0.9 as 9/10, aces curve scaled by 100
  localparam int EXP_NUM = 9;
  localparam int EXP_DEN = 10;
  localparam int ACES_A  = 251;
  localparam int ACES_B  = 3;
  localparam int ACES_C  = 243;
  localparam int ACES_D  = 59;
  localparam int ACES_E  = 14;

  // fixed-point formats
  localparam int V_FRAC  = 40;
  localparam int V_W     = V_FRAC + 3;
  localparam int TM_FRAC = GAMMA_TABLE_BITS + 20;
  localparam int HQ      = 54;
  localparam int NUM_W   = SUM_WIDTH + 4;
  localparam int VSH     = V_FRAC - SUM_FRAC_BITS;
  localparam int DEN_W   = FRAMES_W + 4;
  localparam int B_W     = V_W + 8;
  localparam int ND_W    = V_W + B_W - V_FRAC;
  localparam int A_LO    = V_W / 2;
  localparam int B_LO    = B_W / 2;

  // pipeline shape
  localparam int D1_PER    = 4;
  localparam int D1_STAGES = (V_W + D1_PER - 1) / D1_PER;
  localparam int D2_PER    = 2;
  localparam int D2_STAGES = (TM_FRAC + D2_PER - 1) / D2_PER;
  localparam int S_PER     = 2;
  localparam int S_STAGES  = (BYTE_W + S_PER - 1) / S_PER;
  localparam int LATENCY   = 8 + D1_STAGES + D2_STAGES + S_STAGES;

  localparam int N_THRESH = (1 << BYTE_W) - 1;

  typedef logic [TM_FRAC-1:0] thr_table_t [N_THRESH];

  function automatic logic [63:0] mul_shift_q(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = 128'(x) * 128'(y);
    return p[HQ+63:HQ];
  endfunction

  function automatic logic [63:0] pow5_q(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = mul_shift_q(r, r);
    r4 = mul_shift_q(r2, r2);
    return mul_shift_q(r4, r);
  endfunction

  // code thresholds ((2b-1)/510)^2.2 in the format of the tone mapped value
  function automatic thr_table_t build_thresholds();
    thr_table_t tab;
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] t;
    for (int b = 1; b <= N_THRESH; b++) begin
      a = (64'(2 * b - 1) << HQ) / 64'd510;
      r = '0;
      for (int bi = HQ - 1; bi >= 0; bi--) begin
        c = r | (64'd1 << bi);
        if (pow5_q(c) <= a) r = c;
      end
      t = mul_shift_q(mul_shift_q(a, a), r);
      t = (t + (64'd1 << (HQ - TM_FRAC - 1))) >> (HQ - TM_FRAC);
      tab[b-1] = t[TM_FRAC-1:0];
    end
    return tab;
  endfunction

  localparam thr_table_t THRESH = build_thresholds();

endpackage

[sv/hatg_if.sv]
// valid/ready stream interfaces for the pixel input and the byte output
// depends on hatg_pkg
interface hatg_in_if;
  logic valid;
  logic ready;
  logic [hatg_pkg::SUM_WIDTH-1:0] sum_red;
  logic [hatg_pkg::SUM_WIDTH-1:0] sum_green;
  logic [hatg_pkg::SUM_WIDTH-1:0] sum_blue;
  modport source (output valid, output sum_red, output sum_green, output sum_blue,
                  input ready);
  modport sink (input valid, input sum_red, input sum_green, input sum_blue,
                output ready);
endinterface

interface hatg_out_if;
  logic valid;
  logic ready;
  logic [hatg_pkg::BYTE_W-1:0] out_blue;
  logic [hatg_pkg::BYTE_W-1:0] out_green;
  logic [hatg_pkg::BYTE_W-1:0] out_red;
  modport source (output valid, output out_blue, output out_green, output out_red,
                  input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red,
                output ready);
endinterface

[sv/hdr_average_tonemap_gamma.sv]
// top level of the hdr pixel resolve block: config register, valid pipeline,
// three channel datapaths; depends on hatg_pkg, hatg_if, hatg_channel, assert_macros.svh
//
// Resolves one accumulated HDR pixel per clock, while the output is not stalled,
// into three display bytes. Each 40-bit channel sum (16 fraction bits) is
// divided by frames_accumulated, scaled by 0.9, passed through the ACES filmic
// curve, gamma corrected by 1/2.2 and rounded to a byte; bytes leave as blue,
// green, red. The block is fully pipelined: a new pixel is taken every cycle
// unless the output stalls; the pipeline holds the averaging divider (43
// quotient bits, four per stage), the curve divider (32 quotient bits, two per
// stage), the four-stage multiply chain and the four-stage threshold search.
// When a result is not taken, all stages hold and the input stalls; nothing is
// dropped or repeated. frames_accumulated (reset 1, a stored zero counts as
// one) is written over the apb port at address 0 and must only change while
// the pipeline is empty. No clearing pass after reset.
`include "assert_macros.svh"

module hdr_average_tonemap_gamma (
  input  logic                               clk,
  input  logic                               rst,
  hatg_in_if.sink                            pix_in,
  hatg_out_if.source                         pix_out,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hatg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hatg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hatg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int LAT = hatg_pkg::LATENCY;

  // configuration register and the derived divisor 10 * frames
  logic [hatg_pkg::FRAMES_W-1:0] frames;
  logic [hatg_pkg::DEN_W-1:0]    den;
  logic [hatg_pkg::FRAMES_W-1:0] wr_frames;
  logic [hatg_pkg::FRAMES_W-1:0] eff_frames;
  logic                          cfg_wr;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite
                      && (paddr[hatg_pkg::CFG_ADDR_W-1:2] == hatg_pkg::REG_FRAMES);
  assign wr_frames  = pwdata[hatg_pkg::FRAMES_W-1:0];
  // zero frame count behaves as one
  assign eff_frames = (wr_frames == '0) ? hatg_pkg::FRAMES_W'(1) : wr_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames <= hatg_pkg::FRAMES_W'(hatg_pkg::FRAMES_RESET);
      den    <= hatg_pkg::DEN_W'(hatg_pkg::FRAMES_RESET * hatg_pkg::EXP_DEN);
    end else if (cfg_wr) begin
      frames <= wr_frames;
      den    <= hatg_pkg::DEN_W'(eff_frames) * hatg_pkg::DEN_W'(hatg_pkg::EXP_DEN);
    end
  end

  assign prdata = (paddr[hatg_pkg::CFG_ADDR_W-1:2] == hatg_pkg::REG_FRAMES)
                  ? hatg_pkg::CFG_DATA_W'(frames) : '0;

  // valid bits move with the data; the whole pipe holds while the output stalls
  logic [LAT-1:0] vpipe;
  logic           en;
  logic           accept;

  assign en           = !vpipe[LAT-1] || pix_out.ready;
  assign pix_in.ready = en && !rst;
  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_out.valid = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  // per channel datapaths
  hatg_channel u_red (
    .clk  (clk),
    .en   (en),
    .den  (den),
    .sum  (pix_in.sum_red),
    .code (pix_out.out_red)
  );

  hatg_channel u_green (
    .clk  (clk),
    .en   (en),
    .den  (den),
    .sum  (pix_in.sum_green),
    .code (pix_out.out_green)
  );

  hatg_channel u_blue (
    .clk  (clk),
    .en   (en),
    .den  (den),
    .sum  (pix_in.sum_blue),
    .code (pix_out.out_blue)
  );

  // checks
  `HATG_ASSERT(a_den_nonzero, den != '0, "divisor register is zero")
  `HATG_ASSERT_NEXT(a_stall_holds, !en, $stable(vpipe), "pipeline moved during a stall")
  `HATG_ASSERT_NEXT(a_held_result, pix_out.valid && !pix_out.ready, pix_out.valid,
                    "held result vanished")
  `HATG_ASSERT_NEXT(a_accept_enters, accept, vpipe[0], "accepted pixel not in the pipeline")

endmodule

[sv/hatg_channel.sv]
// one color channel datapath: average, exposure, aces curve, gamma table search
// depends on hatg_pkg; all stages advance together on en
module hatg_channel (
  input  logic                             clk,
  input  logic                             en,
  input  logic [hatg_pkg::DEN_W-1:0]       den,
  input  logic [hatg_pkg::SUM_WIDTH-1:0]   sum,
  output logic [hatg_pkg::BYTE_W-1:0]      code
);

  localparam int QSH   = hatg_pkg::V_W - hatg_pkg::VSH;
  localparam int HI_W  = hatg_pkg::NUM_W - QSH;
  localparam int CMP_W = (HI_W > hatg_pkg::DEN_W) ? HI_W : hatg_pkg::DEN_W;
  localparam int A_HI  = hatg_pkg::V_W - hatg_pkg::A_LO;
  localparam int B_HI  = hatg_pkg::B_W - hatg_pkg::B_LO;
  localparam int W00   = hatg_pkg::A_LO + hatg_pkg::B_LO;
  localparam int W01   = hatg_pkg::A_LO + B_HI;
  localparam int W10   = A_HI + hatg_pkg::B_LO;
  localparam int W11   = A_HI + B_HI;
  localparam int PL_W  = hatg_pkg::A_LO + hatg_pkg::B_W + 1;
  localparam int PH_W  = A_HI + hatg_pkg::B_W + 1;
  localparam int P_W   = hatg_pkg::V_W + hatg_pkg::B_W;
  localparam int DW    = hatg_pkg::DEN_W;
  localparam int NW    = hatg_pkg::ND_W;
  localparam int TM    = hatg_pkg::TM_FRAC;
  localparam int BW    = hatg_pkg::BYTE_W;

  // stage 1: 9 * sum
  logic [hatg_pkg::NUM_W-1:0] num;
  always_ff @(posedge clk) begin
    if (en) num <= hatg_pkg::NUM_W'(sum) * hatg_pkg::NUM_W'(hatg_pkg::EXP_NUM);
  end

  // stage 2: overflow check (v >= 8) and divider setup
  logic [HI_W-1:0]  hi;
  logic [CMP_W-1:0] hi_ext;
  assign hi     = num[hatg_pkg::NUM_W-1:QSH];
  assign hi_ext = CMP_W'(hi);

  logic [DW-1:0]             d1_r   [hatg_pkg::D1_STAGES+1];
  logic [hatg_pkg::V_W-1:0]  d1_x   [hatg_pkg::D1_STAGES+1];
  logic                      d1_big [hatg_pkg::D1_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0]   <= hi_ext[DW-1:0];
      d1_x[0]   <= {num[QSH-1:0], {hatg_pkg::VSH{1'b0}}};
      d1_big[0] <= hi_ext >= CMP_W'(den);
    end
  end

  // restoring divider for v = 9*sum*2^24 / (10*frames), quotient shifts into x
  for (genvar k = 1; k <= hatg_pkg::D1_STAGES; k++) begin : g_div1
    logic [DW-1:0]            r_c;
    logic [hatg_pkg::V_W-1:0] x_c;
    logic [DW:0]              t;
    logic [DW:0]              diff;
    logic                     ge;
    always_comb begin
      r_c  = d1_r[k-1];
      x_c  = d1_x[k-1];
      t    = '0;
      diff = '0;
      ge   = 1'b0;
      for (int j = 0; j < hatg_pkg::D1_PER; j++) begin
        if (((k - 1) * hatg_pkg::D1_PER + j) < hatg_pkg::V_W) begin
          t    = {r_c, x_c[hatg_pkg::V_W-1]};
          diff = t - {1'b0, den};
          ge   = t >= {1'b0, den};
          r_c  = ge ? diff[DW-1:0] : t[DW-1:0];
          x_c  = {x_c[hatg_pkg::V_W-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1_r[k]   <= r_c;
        d1_x[k]   <= x_c;
        d1_big[k] <= d1_big[k-1];
      end
    end
  end

  // curve coefficients 251v + 3 and 243v + 59
  logic [hatg_pkg::V_W-1:0] v;
  logic [hatg_pkg::B_W-1:0] bn;
  logic [hatg_pkg::B_W-1:0] bd;
  logic                     big_bm;
  always_ff @(posedge clk) begin
    if (en) begin
      v      <= d1_x[hatg_pkg::D1_STAGES];
      bn     <= hatg_pkg::B_W'(d1_x[hatg_pkg::D1_STAGES]) * hatg_pkg::B_W'(hatg_pkg::ACES_A)
                + (hatg_pkg::B_W'(hatg_pkg::ACES_B) << hatg_pkg::V_FRAC);
      bd     <= hatg_pkg::B_W'(d1_x[hatg_pkg::D1_STAGES]) * hatg_pkg::B_W'(hatg_pkg::ACES_C)
                + (hatg_pkg::B_W'(hatg_pkg::ACES_D) << hatg_pkg::V_FRAC);
      big_bm <= d1_big[hatg_pkg::D1_STAGES];
    end
  end

  // partial products of v * bn and v * bd
  logic [hatg_pkg::A_LO-1:0] a0;
  logic [A_HI-1:0]           a1;
  assign a0 = v[hatg_pkg::A_LO-1:0];
  assign a1 = v[hatg_pkg::V_W-1:hatg_pkg::A_LO];

  logic [W00-1:0] pn00, pd00;
  logic [W01-1:0] pn01, pd01;
  logic [W10-1:0] pn10, pd10;
  logic [W11-1:0] pn11, pd11;
  logic           big_pp;
  always_ff @(posedge clk) begin
    if (en) begin
      pn00   <= W00'(a0) * W00'(bn[hatg_pkg::B_LO-1:0]);
      pn01   <= W01'(a0) * W01'(bn[hatg_pkg::B_W-1:hatg_pkg::B_LO]);
      pn10   <= W10'(a1) * W10'(bn[hatg_pkg::B_LO-1:0]);
      pn11   <= W11'(a1) * W11'(bn[hatg_pkg::B_W-1:hatg_pkg::B_LO]);
      pd00   <= W00'(a0) * W00'(bd[hatg_pkg::B_LO-1:0]);
      pd01   <= W01'(a0) * W01'(bd[hatg_pkg::B_W-1:hatg_pkg::B_LO]);
      pd10   <= W10'(a1) * W10'(bd[hatg_pkg::B_LO-1:0]);
      pd11   <= W11'(a1) * W11'(bd[hatg_pkg::B_W-1:hatg_pkg::B_LO]);
      big_pp <= big_bm;
    end
  end

  logic [PL_W-1:0] sn_lo, sd_lo;
  logic [PH_W-1:0] sn_hi, sd_hi;
  logic            big_ps;
  always_ff @(posedge clk) begin
    if (en) begin
      sn_lo  <= PL_W'(pn00) + (PL_W'(pn01) << hatg_pkg::B_LO);
      sn_hi  <= PH_W'(pn10) + (PH_W'(pn11) << hatg_pkg::B_LO);
      sd_lo  <= PL_W'(pd00) + (PL_W'(pd01) << hatg_pkg::B_LO);
      sd_hi  <= PH_W'(pd10) + (PH_W'(pd11) << hatg_pkg::B_LO);
      big_ps <= big_pp;
    end
  end

  // full products, drop the 40 fraction bits of v
  logic [P_W-1:0] full_n, full_d;
  assign full_n = P_W'(sn_lo) + (P_W'(sn_hi) << hatg_pkg::A_LO);
  assign full_d = P_W'(sd_lo) + (P_W'(sd_hi) << hatg_pkg::A_LO);

  logic [NW-1:0] n_q, d_q;
  logic          big_nd;
  always_ff @(posedge clk) begin
    if (en) begin
      n_q    <= full_n[P_W-1:hatg_pkg::V_FRAC];
      d_q    <= full_d[P_W-1:hatg_pkg::V_FRAC]
                + (NW'(hatg_pkg::ACES_E) << hatg_pkg::V_FRAC);
      big_nd <= big_ps;
    end
  end

  // second divider f = n * 2^TM / d, saturate when f would reach 1
  logic [NW-1:0] d2_r   [hatg_pkg::D2_STAGES+1];
  logic [NW-1:0] d2_d   [hatg_pkg::D2_STAGES+1];
  logic [TM-1:0] d2_q   [hatg_pkg::D2_STAGES+1];
  logic          d2_sat [hatg_pkg::D2_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0]   <= n_q;
      d2_d[0]   <= d_q;
      d2_q[0]   <= '0;
      d2_sat[0] <= big_nd || (n_q >= d_q);
    end
  end

  for (genvar k = 1; k <= hatg_pkg::D2_STAGES; k++) begin : g_div2
    logic [NW-1:0] r_c;
    logic [TM-1:0] q_c;
    logic [NW:0]   t;
    logic [NW:0]   diff;
    logic          ge;
    always_comb begin
      r_c  = d2_r[k-1];
      q_c  = d2_q[k-1];
      t    = '0;
      diff = '0;
      ge   = 1'b0;
      for (int j = 0; j < hatg_pkg::D2_PER; j++) begin
        if (((k - 1) * hatg_pkg::D2_PER + j) < TM) begin
          t    = {r_c, 1'b0};
          diff = t - {1'b0, d2_d[k-1]};
          ge   = t >= {1'b0, d2_d[k-1]};
          r_c  = ge ? diff[NW-1:0] : t[NW-1:0];
          q_c  = {q_c[TM-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2_r[k]   <= r_c;
        d2_d[k]   <= d2_d[k-1];
        d2_q[k]   <= q_c;
        d2_sat[k] <= d2_sat[k-1];
      end
    end
  end

  // binary search over the sorted thresholds: code = count of thresholds <= f
  logic [TM-1:0] s_f   [hatg_pkg::S_STAGES];
  logic [BW-1:0] s_pos [hatg_pkg::S_STAGES];
  logic          s_sat [hatg_pkg::S_STAGES];

  for (genvar k = 0; k < hatg_pkg::S_STAGES; k++) begin : g_srch
    logic [TM-1:0] f_in;
    logic [BW-1:0] p_in;
    logic          sat_in;
    logic [BW-1:0] pos_c;
    logic [BW-1:0] cand;
    if (k == 0) begin : g_src
      assign f_in   = d2_q[hatg_pkg::D2_STAGES];
      assign p_in   = '0;
      assign sat_in = d2_sat[hatg_pkg::D2_STAGES];
    end else begin : g_src
      assign f_in   = s_f[k-1];
      assign p_in   = s_pos[k-1];
      assign sat_in = s_sat[k-1];
    end
    always_comb begin
      pos_c = p_in;
      cand  = '0;
      for (int j = 0; j < hatg_pkg::S_PER; j++) begin
        if ((k * hatg_pkg::S_PER + j) < BW) begin
          cand = pos_c | (BW'(1) << (BW - 1 - (k * hatg_pkg::S_PER + j)));
          if (f_in >= hatg_pkg::THRESH[cand - BW'(1)]) pos_c = cand;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_f[k]   <= f_in;
        s_pos[k] <= pos_c;
        s_sat[k] <= sat_in;
      end
    end
  end

  // output byte
  always_ff @(posedge clk) begin
    if (en) begin
      code <= s_sat[hatg_pkg::S_STAGES-1] ? {BW{1'b1}} : s_pos[hatg_pkg::S_STAGES-1];
    end
  end

endmodule

[test/hatg_checker.sv]
// checker for the hdr resolve block: watches the pixel, byte and apb channels,
// predicts every byte triple and compares it; depends on hatg_pkg and hatg_if
module hatg_checker (
  input  logic  clk,
  input  logic  rst,
  hatg_in_if    pix_mon,
  hatg_out_if   byte_mon,
  input  logic  psel,
  input  logic  penable,
  input  logic  pwrite,
  input  logic  pready,
  input  logic [hatg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hatg_pkg::CFG_DATA_W-1:0] pwdata,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FMT = hatg_pkg::GAMMA_TABLE_BITS + 20;
  localparam int Q   = 54;
  localparam int VF  = 40;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  bgr_t bgr_queue[$];
  logic [23:0] frames;
  logic [63:0] code_edge[255];

  function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = 128'(x) * 128'(y);
    return 64'(p >> Q);
  endfunction

  function automatic logic [63:0] fifth(input logic [63:0] r);
    logic [63:0] sq;
    sq = fx_mul(r, r);
    return fx_mul(fx_mul(sq, sq), r);
  endfunction

  // byte edges ((2b-1)/510)^2.2, fifth root found bit by bit
  initial begin
    logic [63:0] a, root, cand, t;
    for (int b = 1; b <= 255; b++) begin
      a = (64'(2 * b - 1) << Q) / 64'd510;
      root = '0;
      for (int k = Q - 1; k >= 0; k--) begin
        cand = root | (64'd1 << k);
        if (fifth(cand) <= a) root = cand;
      end
      t = fx_mul(fx_mul(a, a), root);
      code_edge[b-1] = (t + (64'd1 << (Q - FMT - 1))) >> (Q - FMT);
    end
  end

  function automatic logic [7:0] tonemap_byte(input logic [39:0] sum,
                                             input logic [23:0] fr);
    logic [63:0] fr_eff, sat, num, den, q0, r0, v, one;
    logic [127:0] n, d, f;
    int code;
    fr_eff = (fr == 0) ? 64'd1 : 64'(fr);
    sat = ((fr_eff * 64'd80) << hatg_pkg::SUM_FRAC_BITS);
    sat = (sat + 64'd8) / 64'd9;
    if (64'(sum) >= sat) return 8'd255;
    num = 64'd9 * 64'(sum);
    den = fr_eff * 64'd10;
    q0 = num / den;
    r0 = num % den;
    v = (q0 << (VF - hatg_pkg::SUM_FRAC_BITS))
      + ((r0 << (VF - hatg_pkg::SUM_FRAC_BITS)) / den);
    one = 64'd1 << VF;
    n = (128'(v) * 128'(64'd251 * v + 64'd3 * one)) >> VF;
    d = ((128'(v) * 128'(64'd243 * v + 64'd59 * one)) >> VF) + 128'(64'd14 * one);
    if (n >= d) return 8'd255;
    f = (n << FMT) / d;
    code = 0;
    for (int i = 0; i < 255; i++)
      if (f >= 128'(code_edge[i])) code++;
    return 8'(code);
  endfunction

  assign pending = bgr_queue.size();

  always @(posedge clk) begin
    bgr_t got, want;
    if (rst) begin
      frames = 24'd1;
      bgr_queue.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) == hatg_pkg::REG_FRAMES)
        frames = pwdata[23:0];
      if (byte_mon.valid && byte_mon.ready) begin
        got = '{byte_mon.out_blue, byte_mon.out_green, byte_mon.out_red};
        if (bgr_queue.size() == 0) begin
          $error("unexpected byte transfer b=%0d g=%0d r=%0d", got.blue, got.green, got.red);
          fail_count++;
        end else begin
          want = bgr_queue.pop_front();
          if (got.blue !== want.blue) begin
            $error("out_blue expected %0d got %0d", want.blue, got.blue);
            fail_count++;
          end
          if (got.green !== want.green) begin
            $error("out_green expected %0d got %0d", want.green, got.green);
            fail_count++;
          end
          if (got.red !== want.red) begin
            $error("out_red expected %0d got %0d", want.red, got.red);
            fail_count++;
          end
        end
      end
      if (pix_mon.valid && pix_mon.ready)
        bgr_queue.push_back('{tonemap_byte(pix_mon.sum_blue, frames),
                              tonemap_byte(pix_mon.sum_green, frames),
                              tonemap_byte(pix_mon.sum_red, frames)});
    end
  end
endmodule

[test/hdr_average_tonemap_gamma_tb.sv]
// testbench top for the hdr resolve block: clock, reset, pixel stimulus, byte
// sink, apb writes and verdict; depends on hatg_pkg, hatg_if and hatg_checker
module hdr_average_tonemap_gamma_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_UNUSED = 1;       // index with no register behind it
  localparam int WATCHDOG   = 5000;    // cycles with no transfer at all
  localparam int LONG_STALL = 200;
  localparam logic [39:0] SUM_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [hatg_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [hatg_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [hatg_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  hatg_in_if  pix_in();
  hatg_out_if pix_out();

  int  fail_count, pending;
  bit  quiet = 0;            // no idling on either side
  int  stall_req = 0;        // bumped to ask the sink for one long hold-off
  int  sent = 0;
  int  idle_wd = 0;
  logic [23:0] cur_frames = 24'd1;

  always #10 clk = ~clk;

  hdr_average_tonemap_gamma DUT (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  hatg_checker u_checker (
    .clk(clk), .rst(rst), .pix_mon(pix_in), .byte_mon(pix_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  // byte sink: random short hold-offs, one long one on request
  always @(posedge clk) begin
    static int idle_left = 0, stall_left = 0, stall_served = 0;
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_out.ready <= 1'b0;
    end else if (stall_served != stall_req) begin
      stall_served = stall_req;
      stall_left = LONG_STALL - 1;
      pix_out.ready <= 1'b0;
    end else if (idle_left > 0) begin
      idle_left--;
      pix_out.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      idle_left = $urandom_range(0, 2);
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      idle_wd <= 0;
    end else if (idle_wd >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("hdr_average_tonemap_gamma_tb NOT OK");
      $finish;
    end else begin
      idle_wd <= idle_wd + 1;
    end
  end

  // one pixel transfer; valid stays high into the next item unless a gap is drawn
  task automatic send_pixel(input logic [39:0] r, input logic [39:0] g,
                            input logic [39:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.sum_red <= r;
    pix_in.sum_green <= g;
    pix_in.sum_blue <= b;
    do @(posedge clk); while (!pix_in.ready);
    sent++;
  endtask

  task automatic apb_write(input int index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= hatg_pkg::CFG_ADDR_W'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // lets every expected byte triple arrive, then the pipeline drain
  task automatic drain();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (hatg_pkg::LATENCY + 5) @(posedge clk);
  endtask

  // saturation edge of the current frame count, clamped to the sum range
  function automatic logic [39:0] sat_edge();
    logic [63:0] fr, t;
    fr = (cur_frames == 0) ? 64'd1 : 64'(cur_frames);
    t = ((fr * 64'd80) << hatg_pkg::SUM_FRAC_BITS);
    t = (t + 64'd8) / 64'd9;
    return (t > 64'(SUM_MAX)) ? SUM_MAX : t[39:0];
  endfunction

  // random sum: full range, log-spread, or scaled to the frame count
  function automatic logic [39:0] rand_sum();
    logic [63:0] w;
    case ($urandom_range(0, 3))
      0: w = {$urandom, $urandom};
      1: w = {$urandom, $urandom} >> $urandom_range(20, 63);
      default: w = 64'((cur_frames == 0) ? 1 : cur_frames)
                   * 64'($urandom_range(0, 9 << hatg_pkg::SUM_FRAC_BITS));
    endcase
    return w[39:0];
  endfunction

  task automatic run_phase(input logic [23:0] frames_set, input int n_rand,
                           input bit pressure);
    logic [39:0] e;
    drain();
    apb_write(hatg_pkg::REG_FRAMES, {8'h0, frames_set});
    cur_frames = frames_set;
    e = sat_edge();
    // directed: zero, full scale, just below and at saturation, tiny values
    send_pixel('0, '0, '0);
    send_pixel(SUM_MAX, SUM_MAX, SUM_MAX);
    send_pixel(e - 40'd1, e, e - 40'd1);
    send_pixel(40'd1, 40'd1 << hatg_pkg::SUM_FRAC_BITS, e - 40'd2);
    for (int i = 0; i < n_rand; i++) begin
      if (pressure && i == 20) stall_req++;
      if (pressure && i == n_rand / 2) begin
        // sender holds until every byte triple is back
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_pixel(rand_sum(), rand_sum(), rand_sum());
    end
  endtask

  initial begin
    pix_in.valid <= 1'b0;
    pix_in.sum_red <= '0;
    pix_in.sum_green <= '0;
    pix_in.sum_blue <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_write(REG_UNUSED, 32'h00ABCDEF);     // no register there, must be ignored
    run_phase(24'd1, 170, 1'b0);
    run_phase(24'd0, 170, 1'b1);             // zero count acts as one
    run_phase(24'hFFFFFF, 170, 1'b0);
    run_phase(24'd3, 170, 1'b0);
    run_phase(24'($urandom_range(2, 5000)), 170, 1'b0);
    quiet = 1;
    run_phase(24'd1000, 170, 1'b0);
    drain();
    $display("covered %0d pixels over six frame counts incl. 0 and 2^24-1,", sent);
    $display("with saturation edges, a long output stall and a sender pause");
    if (fail_count == 0) begin
      $display("hdr_average_tonemap_gamma_tb OK");
    end else begin
      $display("hdr_average_tonemap_gamma_tb NOT OK");
    end
    $finish;
  end
endmodule
